FILE: design/assert_macros.svh
// Shared assertion macros, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds.
`define KCS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kcs assertion failed");

// Check that an expression never holds.
`define KCS_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("kcs forbidden condition seen");

`endif

FILE: design/kcs_pkg.sv
package kcs_pkg;

  localparam int LVL_W = 2;

  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [1:0]       child_t;

  localparam child_t CHILD_LAST = 2'd3;
  localparam lvl_t   DEPTH_RESET = 2'd2;

  localparam int           FRAC_BITS      = 16;
  localparam logic [15:0]  SQRT3_HALF_Q16 = 16'd56756;
  localparam logic [16:0]  HALF_LSB_Q16   = 17'd32768;

  typedef struct packed {
    logic load;
    logic adv;
  } kcs_ctrl_t;

  typedef struct packed {
    logic done;
    logic last_child;
  } kcs_stat_t;

endpackage

FILE: design/kcs_if.sv
interface kcs_seg_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface kcs_leaf_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_x0;
  logic signed [COORD_WIDTH-1:0] seg_y0;
  logic signed [COORD_WIDTH-1:0] seg_x1;
  logic signed [COORD_WIDTH-1:0] seg_y1;
  logic                          saturated;
  logic                          last;

  modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, saturated, last,
                  input ready);
  modport sink (input valid, seg_x0, seg_y0, seg_x1, seg_y1, saturated, last,
                output ready);
endinterface

interface kcs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] depth_level;

  modport source (output valid, depth_level, input ready);
  modport sink (input valid, depth_level, output ready);
endinterface

FILE: design/kcs_expand.sv
module kcs_expand #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COORD_WIDTH-1:0] s_x,
  input  logic signed [COORD_WIDTH-1:0] s_y,
  input  logic signed [COORD_WIDTH-1:0] e_x,
  input  logic signed [COORD_WIDTH-1:0] e_y,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] m1_x,
  output logic signed [COORD_WIDTH-1:0] m1_y,
  output logic signed [COORD_WIDTH-1:0] pk_x,
  output logic signed [COORD_WIDTH-1:0] pk_y,
  output logic signed [COORD_WIDTH-1:0] m2_x,
  output logic signed [COORD_WIDTH-1:0] m2_y,
  output logic                          m1_sat,
  output logic                          m2_sat,
  output logic                          pk_sat
);
  import kcs_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int N = W + 1;
  localparam logic [N-1:0] RECIP3 = N'(((N+1)'(1) << N) / 3);

  function automatic logic [W:0] sat_fn(input logic [W+2:0] v);
    logic ovf;
    logic [W-1:0] r;
    ovf = !((&v[W+2:W-1]) || (~|v[W+2:W-1]));
    if (!ovf) begin
      r = v[W-1:0];
    end else if (v[W+2]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return {ovf, r};
  endfunction

  logic [5:0] vld;

  logic [W+1:0] sum1 [4];
  logic [W+1:0] mag1 [4];
  logic [N-1:0] x1 [4];
  logic         n1 [4];

  logic [2*N-1:0] p2 [4];
  logic [N-1:0]   x2 [4];
  logic           n2 [4];

  logic [N-1:0] qe3 [4];
  logic [N-1:0] r3 [4];
  logic [N-1:0] q3 [4];
  logic [W+1:0] sv3 [4];
  logic [W:0]   st3 [4];
  logic signed [W-1:0] m3 [4];
  logic                ms3 [4];

  logic [W:0]   msum4x, msum4y, mrnd4x, mrnd4y, diff4x, diff4y, dabs4x, dabs4y;
  logic signed [W-1:0] mid4x, mid4y;
  logic [W-1:0] dm4x, dm4y;
  logic         dn4x, dn4y;
  logic signed [W-1:0] m4 [4];
  logic                ms4 [4];

  logic [W+15:0] kp5x, kp5y;
  logic signed [W-1:0] mid5x, mid5y;
  logic         kn5x, kn5y;
  logic signed [W-1:0] m5 [4];
  logic                ms5 [4];

  logic [W+16:0] kr6x, kr6y;
  logic [W:0]    rk6x, rk6y;
  logic [W+1:0]  t6x, t6y;
  logic [W+2:0]  pv6x, pv6y;
  logic [W:0]    ps6x, ps6y;

  always_comb begin
    sum1[0] = {{2{s_x[W-1]}}, s_x} + {{2{s_x[W-1]}}, s_x} + {{2{e_x[W-1]}}, e_x};
    sum1[1] = {{2{s_y[W-1]}}, s_y} + {{2{s_y[W-1]}}, s_y} + {{2{e_y[W-1]}}, e_y};
    sum1[2] = {{2{s_x[W-1]}}, s_x} + {{2{e_x[W-1]}}, e_x} + {{2{e_x[W-1]}}, e_x};
    sum1[3] = {{2{s_y[W-1]}}, s_y} + {{2{e_y[W-1]}}, e_y} + {{2{e_y[W-1]}}, e_y};
    for (int j = 0; j < 4; j++) begin
      mag1[j] = sum1[j][W+1] ? -sum1[j] : sum1[j];
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      qe3[j] = p2[j][2*N-1:N];
      r3[j]  = x2[j] - ((qe3[j] << 1) + qe3[j]);
      q3[j]  = (r3[j] >= N'(3)) ? qe3[j] + N'(1) : qe3[j];
      sv3[j] = n2[j] ? -{1'b0, q3[j]} : {1'b0, q3[j]};
      st3[j] = sat_fn({sv3[j][W+1], sv3[j]});
    end
  end

  always_comb begin
    msum4x = {m3[0][W-1], m3[0]} + {m3[2][W-1], m3[2]};
    msum4y = {m3[1][W-1], m3[1]} + {m3[3][W-1], m3[3]};
    mrnd4x = msum4x[W] ? msum4x : msum4x + (W+1)'(1);
    mrnd4y = msum4y[W] ? msum4y : msum4y + (W+1)'(1);
    diff4x = {m3[2][W-1], m3[2]} - {m3[0][W-1], m3[0]};
    diff4y = {m3[3][W-1], m3[3]} - {m3[1][W-1], m3[1]};
    dabs4x = diff4x[W] ? -diff4x : diff4x;
    dabs4y = diff4y[W] ? -diff4y : diff4y;
  end

  always_comb begin
    kr6x = {1'b0, kp5x} + (W+17)'(HALF_LSB_Q16);
    kr6y = {1'b0, kp5y} + (W+17)'(HALF_LSB_Q16);
    rk6x = kr6x[W+16:FRAC_BITS];
    rk6y = kr6y[W+16:FRAC_BITS];
    t6x  = kn5x ? -{1'b0, rk6x} : {1'b0, rk6x};
    t6y  = kn5y ? -{1'b0, rk6y} : {1'b0, rk6y};
    pv6x = {{3{mid5x[W-1]}}, mid5x} + {t6x[W+1], t6x};
    pv6y = {{3{mid5y[W-1]}}, mid5y} - {t6y[W+1], t6y};
    ps6x = sat_fn(pv6x);
    ps6y = sat_fn(pv6y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      x1[j]  <= mag1[j][N-1:0] + N'(1);
      n1[j]  <= sum1[j][W+1];
      p2[j]  <= {{N{1'b0}}, x1[j]} * {{N{1'b0}}, RECIP3};
      x2[j]  <= x1[j];
      n2[j]  <= n1[j];
      m3[j]  <= st3[j][W-1:0];
      ms3[j] <= st3[j][W];
      m4[j]  <= m3[j];
      ms4[j] <= ms3[j];
      m5[j]  <= m4[j];
      ms5[j] <= ms4[j];
    end
    mid4x <= mrnd4x[W:1];
    mid4y <= mrnd4y[W:1];
    dm4x  <= dabs4x[W-1:0];
    dm4y  <= dabs4y[W-1:0];
    dn4x  <= diff4x[W];
    dn4y  <= diff4y[W];
    kp5x  <= {16'd0, dm4y} * {{W{1'b0}}, SQRT3_HALF_Q16};
    kp5y  <= {16'd0, dm4x} * {{W{1'b0}}, SQRT3_HALF_Q16};
    kn5x  <= dn4y;
    kn5y  <= dn4x;
    mid5x <= mid4x;
    mid5y <= mid4y;
    m1_x   <= m5[0];
    m1_y   <= m5[1];
    m2_x   <= m5[2];
    m2_y   <= m5[3];
    m1_sat <= ms5[0] | ms5[1];
    m2_sat <= ms5[2] | ms5[3];
    pk_x   <= ps6x[W-1:0];
    pk_y   <= ps6y[W-1:0];
    pk_sat <= ps6x[W] | ps6y[W];
  end

  assign done = vld[5];

endmodule

FILE: design/kcs_cell.sv
module kcs_cell #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kcs_pkg::kcs_ctrl_t            ctrl,
  input  logic signed [COORD_WIDTH-1:0] left_x0,
  input  logic signed [COORD_WIDTH-1:0] left_y0,
  input  logic                          left_s0,
  input  logic signed [COORD_WIDTH-1:0] left_x1,
  input  logic signed [COORD_WIDTH-1:0] left_y1,
  input  logic                          left_s1,
  output logic signed [COORD_WIDTH-1:0] seg_x0,
  output logic signed [COORD_WIDTH-1:0] seg_y0,
  output logic                          seg_s0,
  output logic signed [COORD_WIDTH-1:0] seg_x1,
  output logic signed [COORD_WIDTH-1:0] seg_y1,
  output logic                          seg_s1,
  output kcs_pkg::kcs_stat_t            stat
);
  import kcs_pkg::*;

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] px [5];
  logic signed [W-1:0] py [5];
  logic                ps [5];
  child_t              child;

  logic                xdone;
  logic signed [W-1:0] m1_x, m1_y, pk_x, pk_y, m2_x, m2_y;
  logic                m1_sat, m2_sat, pk_sat;

  kcs_expand #(.COORD_WIDTH(W)) u_expand (
    .clk    (clk),
    .rst    (rst),
    .start  (ctrl.load),
    .s_x    (left_x0),
    .s_y    (left_y0),
    .e_x    (left_x1),
    .e_y    (left_y1),
    .done   (xdone),
    .m1_x   (m1_x),
    .m1_y   (m1_y),
    .pk_x   (pk_x),
    .pk_y   (pk_y),
    .m2_x   (m2_x),
    .m2_y   (m2_y),
    .m1_sat (m1_sat),
    .m2_sat (m2_sat),
    .pk_sat (pk_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      child <= '0;
    end else if (ctrl.load) begin
      child <= '0;
    end else if (ctrl.adv) begin
      child <= child + child_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      px[0] <= left_x0;
      py[0] <= left_y0;
      ps[0] <= left_s0;
      px[4] <= left_x1;
      py[4] <= left_y1;
      ps[4] <= left_s1;
    end else if (xdone) begin
      px[1] <= m1_x;
      py[1] <= m1_y;
      ps[1] <= m1_sat;
      px[2] <= pk_x;
      py[2] <= pk_y;
      ps[2] <= pk_sat;
      px[3] <= m2_x;
      py[3] <= m2_y;
      ps[3] <= m2_sat;
    end else if (ctrl.adv) begin
      for (int j = 0; j < 4; j++) begin
        px[j] <= px[j+1];
        py[j] <= py[j+1];
        ps[j] <= ps[j+1];
      end
    end
  end

  assign seg_x0 = px[0];
  assign seg_y0 = py[0];
  assign seg_s0 = ps[0];
  assign seg_x1 = px[1];
  assign seg_y1 = py[1];
  assign seg_s1 = ps[1];

  assign stat.done       = xdone;
  assign stat.last_child = (child == CHILD_LAST);

endmodule

FILE: design/koch_curve_subdivider.sv
// Channel   Interface     Role    Moves
// cfg       kcs_cfg_if    sink    depth_level register write
// segment   kcs_seg_if    sink    one input segment per transaction
// leaf      kcs_leaf_if   source  one leaf segment per transaction
//
// Depth d: 4^d leaf transactions per segment; each of the (4^d-1)/3 expansions runs
// through the expander and then hands the child down to the next level's cell.
// rst clears control state and sets depth_level to 2; cfg is always ready.
// A stalled leaf holds the output register and freezes the walk at the next leaf;
// a new segment is taken once the previous one has its last leaf in the output register.
`include "assert_macros.svh"

module koch_curve_subdivider #(
  parameter int MAX_DEPTH   = 3,
  parameter int COORD_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  kcs_cfg_if.sink    cfg,
  kcs_seg_if.sink    segment,
  kcs_leaf_if.source leaf
);
  import kcs_pkg::*;

  localparam int W = COORD_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_EXP   = 3'd2;
  localparam logic [2:0] S_DESC  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_PASS  = 3'd5;

  logic [2:0] state, state_next;
  lvl_t       depth_level, d_eff, dep, lvl, lvl_next;

  logic signed [W-1:0] in_x0, in_y0, in_x1, in_y1;

  logic                ovalid;
  logic signed [W-1:0] ox0, oy0, ox1, oy1;
  logic                osat, olast;

  kcs_ctrl_t           ctrl [MAX_DEPTH];
  kcs_stat_t           stat [MAX_DEPTH];
  logic signed [W-1:0] lx0 [MAX_DEPTH];
  logic signed [W-1:0] ly0 [MAX_DEPTH];
  logic                ls0 [MAX_DEPTH];
  logic signed [W-1:0] lx1 [MAX_DEPTH];
  logic signed [W-1:0] ly1 [MAX_DEPTH];
  logic                ls1 [MAX_DEPTH];
  logic signed [W-1:0] cx0 [MAX_DEPTH];
  logic signed [W-1:0] cy0 [MAX_DEPTH];
  logic                cs0 [MAX_DEPTH];
  logic signed [W-1:0] cx1 [MAX_DEPTH];
  logic signed [W-1:0] cy1 [MAX_DEPTH];
  logic                cs1 [MAX_DEPTH];

  logic signed [W-1:0] sx0, sy0, sx1, sy1;
  logic                ss0, ss1, lc_sel, done_sel, at_leaf, out_free, out_load;
  logic                found, load_en, adv_en, out_last;
  lvl_t                k, load_lvl, adv_lvl;

  assign cfg.ready     = 1'b1;
  assign segment.ready = (state == S_IDLE);
  assign d_eff = (depth_level > lvl_t'(MAX_DEPTH)) ? lvl_t'(MAX_DEPTH) : depth_level;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lx0[i] = in_x0;
      assign ly0[i] = in_y0;
      assign ls0[i] = 1'b0;
      assign lx1[i] = in_x1;
      assign ly1[i] = in_y1;
      assign ls1[i] = 1'b0;
    end else begin : g_link
      assign lx0[i] = cx0[i-1];
      assign ly0[i] = cy0[i-1];
      assign ls0[i] = cs0[i-1];
      assign lx1[i] = cx1[i-1];
      assign ly1[i] = cy1[i-1];
      assign ls1[i] = cs1[i-1];
    end

    kcs_cell #(.COORD_WIDTH(W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl[i]),
      .left_x0 (lx0[i]),
      .left_y0 (ly0[i]),
      .left_s0 (ls0[i]),
      .left_x1 (lx1[i]),
      .left_y1 (ly1[i]),
      .left_s1 (ls1[i]),
      .seg_x0  (cx0[i]),
      .seg_y0  (cy0[i]),
      .seg_s0  (cs0[i]),
      .seg_x1  (cx1[i]),
      .seg_y1  (cy1[i]),
      .seg_s1  (cs1[i]),
      .stat    (stat[i])
    );
  end

  always_comb begin
    sx0 = '0;
    sy0 = '0;
    ss0 = 1'b0;
    sx1 = '0;
    sy1 = '0;
    ss1 = 1'b0;
    lc_sel   = 1'b0;
    done_sel = 1'b0;
    found    = 1'b0;
    k        = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (lvl == lvl_t'(i)) begin
        sx0 = cx0[i];
        sy0 = cy0[i];
        ss0 = cs0[i];
        sx1 = cx1[i];
        sy1 = cy1[i];
        ss1 = cs1[i];
        lc_sel   = stat[i].last_child;
        done_sel = stat[i].done;
      end
      if ((lvl_t'(i) < lvl) && !stat[i].last_child) begin
        found = 1'b1;
        k     = lvl_t'(i);
      end
    end
  end

  assign at_leaf  = (lvl_t'(lvl + lvl_t'(1)) == dep);
  assign out_free = !ovalid || leaf.ready;

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    load_en    = 1'b0;
    load_lvl   = '0;
    adv_en     = 1'b0;
    adv_lvl    = lvl;
    out_load   = 1'b0;
    out_last   = 1'b0;
    case (state)
      S_IDLE: begin
        if (segment.valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (dep == '0) begin
          state_next = S_PASS;
        end else begin
          load_en    = 1'b1;
          load_lvl   = '0;
          lvl_next   = '0;
          state_next = S_EXP;
        end
      end
      S_EXP: begin
        if (done_sel) begin
          state_next = at_leaf ? S_EMIT : S_DESC;
        end
      end
      S_DESC: begin
        load_en    = 1'b1;
        load_lvl   = lvl_t'(lvl + lvl_t'(1));
        lvl_next   = lvl_t'(lvl + lvl_t'(1));
        state_next = S_EXP;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = lc_sel && !found;
          if (!lc_sel) begin
            adv_en = 1'b1;
          end else if (found) begin
            adv_en     = 1'b1;
            adv_lvl    = k;
            lvl_next   = k;
            state_next = S_DESC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PASS: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      ctrl[i].load = load_en && (load_lvl == lvl_t'(i));
      ctrl[i].adv  = adv_en && (adv_lvl == lvl_t'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_level <= DEPTH_RESET;
    end else if (cfg.valid) begin
      depth_level <= cfg.depth_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      lvl    <= '0;
      dep    <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      if (segment.valid && segment.ready) begin
        dep <= d_eff;
      end
      if (out_load) begin
        ovalid <= 1'b1;
      end else if (leaf.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (segment.valid && segment.ready) begin
      in_x0 <= segment.start_x;
      in_y0 <= segment.start_y;
      in_x1 <= segment.end_x;
      in_y1 <= segment.end_y;
    end
    if (out_load) begin
      if (state == S_PASS) begin
        ox0  <= in_x0;
        oy0  <= in_y0;
        ox1  <= in_x1;
        oy1  <= in_y1;
        osat <= 1'b0;
      end else begin
        ox0  <= sx0;
        oy0  <= sy0;
        ox1  <= sx1;
        oy1  <= sy1;
        osat <= ss0 | ss1;
      end
      olast <= out_last;
    end
  end

  assign leaf.valid     = ovalid;
  assign leaf.seg_x0    = ox0;
  assign leaf.seg_y0    = oy0;
  assign leaf.seg_x1    = ox1;
  assign leaf.seg_y1    = oy1;
  assign leaf.saturated = osat;
  assign leaf.last      = olast;

  `KCS_ASSERT(a_emit_at_leaf, (state == S_EMIT) |-> at_leaf)
  `KCS_ASSERT(a_last_to_idle, (out_load && out_last) |=> (state == S_IDLE))
  `KCS_NEVER(a_lvl_in_range, ((state == S_EXP) || (state == S_DESC)) && (lvl >= dep))
  `KCS_ASSERT(a_pass_only_flat, (state == S_PASS) |-> (dep == '0))

endmodule
